// ===== rtl/htlp_pkg.sv =====
// ----------------------------------------------------------------------------
// htlp_pkg: shared types and constants for the linear-probe hash table
// Request/status codes, key width, empty marker and controller states.
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int KEY_W = 31;
  localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

  // Padded key is consumed one nibble per cycle by the home-slot reduction
  localparam int PAD_W = 32;
  localparam int NIBBLES = PAD_W / 4;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RESERVED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_REDUCE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } back_state_t;

endpackage

// ===== rtl/htlp_if.sv =====
// ----------------------------------------------------------------------------
// htlp_if: request and response channels of the hash table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface htlp_req_if import htlp_pkg::*; ();
  logic             valid;
  logic             ready;
  req_t             req_type;
  logic [KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface htlp_rsp_if import htlp_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [3:0] slot_index;
  logic [3:0] occupied;

  modport source (output valid, output status, output slot_index, output occupied,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input occupied,
                  output ready);
endinterface

// ===== rtl/hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// hash_table_linear_probe: open-addressing hash table, linear probing
// Intake takes a new request only once it is idle again, after the nibble-wide
// home-slot reduction and the push to the queue; the probe engine probes k slots,
// k up to TABLE_SIZE, one memory read a cycle.
// Synchronous reset; the engine then clears TABLE_SIZE slots, one a cycle.
// ----------------------------------------------------------------------------
module hash_table_linear_probe import htlp_pkg::*; #(
  parameter int TABLE_SIZE = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  htlp_req_if.sink    in_ch,
  htlp_rsp_if.source  out_ch
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int QW    = 2 + KEY_W + IDX_W;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  // Intake and home-slot reduction
  htlp_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W),
    .QW         (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue
  htlp_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Probe engine and slot memory
  htlp_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .QW         (QW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/htlp_front.sv =====
// ----------------------------------------------------------------------------
// htlp_front: request intake and home-slot computation
// Takes one request beat, reduces the key modulo the table size one nibble
// per cycle, flags the reserved key and pushes the request to the queue.
// ----------------------------------------------------------------------------
module htlp_front import htlp_pkg::*; #(
  parameter int TABLE_SIZE = 13,
  parameter int IDX_W      = 4,
  parameter int QW         = 2 + KEY_W + IDX_W
) (
  input  logic           clk,
  input  logic           rst_n,
  htlp_req_if.sink       in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output logic [QW-1:0]  push_data
);

  localparam int T_W = IDX_W + 4;
  localparam logic [T_W-1:0] MOD_T = T_W'(TABLE_SIZE);
  localparam logic [2:0] LAST_STEP = 3'(NIBBLES - 1);

  front_state_t     state_r, state_nxt;
  req_t             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAD_W-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [T_W-1:0]   t_red;
  logic             reserved;

  // Reduce (rem * 16 + nibble) below TABLE_SIZE by subtracting 8N, 4N, 2N, N
  always_comb begin
    t_red = {rem_r, sh_r[PAD_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (t_red >= (MOD_T << k)) begin
        t_red = t_red - (MOD_T << k);
      end
    end
  end

  assign reserved   = (key_r == EMPTY_KEY);
  assign push_data  = {op_r, reserved, key_r, rem_r};
  assign push_valid = (state_r == FR_PUSH);
  assign in_ch.ready = (state_r == FR_IDLE);

  // State and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  // Next state: capture, reduce for one nibble a cycle, hand off
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    case (state_r)
      FR_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.req_type;
          key_nxt   = in_ch.key;
          sh_nxt    = {1'b0, in_ch.key};
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = FR_REDUCE;
        end
      end
      FR_REDUCE: begin
        rem_nxt  = t_red[IDX_W-1:0];
        sh_nxt   = sh_r << 4;
        step_nxt = step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (push_ready) begin
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/htlp_fifo.sv =====
// ----------------------------------------------------------------------------
// htlp_fifo: two-entry queue between request intake and the probe engine
// Lets the front finish a request while the back is still probing.
// ----------------------------------------------------------------------------
module htlp_fifo #(
  parameter int WIDTH = 37
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== rtl/htlp_back.sv =====
// ----------------------------------------------------------------------------
// htlp_back: probe engine, slot memory and result register
// Clears the slot memory after reset, then walks slots from home, one read
// issued per cycle, checks each returned slot and writes on insert.
// ----------------------------------------------------------------------------
module htlp_back import htlp_pkg::*; #(
  parameter int TABLE_SIZE = 13,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 4,
  parameter int QW         = 2 + KEY_W + IDX_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  htlp_rsp_if.source    out_ch
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  // Slot memory
  logic [KEY_W-1:0] mem [TABLE_SIZE];
  logic [KEY_W-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [KEY_W-1:0] mem_wd;

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             iss_r, iss_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_pos_r, chk_pos_nxt;
  logic             chk_last_r, chk_last_nxt;
  req_t             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [3:0]       out_idx_r, out_idx_nxt;
  logic [3:0]       out_occ_r, out_occ_nxt;

  // Queue entry fields
  req_t             q_op;
  logic             q_res;
  logic [KEY_W-1:0] q_key;
  logic [IDX_W-1:0] q_home;

  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W+3:0] occ_now_ext, occ_inc_ext;
  logic [IDX_W+3:0] idx_ext;
  logic             out_free;

  assign q_op   = req_t'(q_data[QW-1]);
  assign q_res  = q_data[QW-2];
  assign q_key  = q_data[QW-3 -: KEY_W];
  assign q_home = q_data[IDX_W-1:0];

  // Result fields keep the low four bits of index and count
  assign fill_inc    = fill_r + CNT_W'(1);
  assign occ_now_ext = {4'b0, fill_r};
  assign occ_inc_ext = {4'b0, fill_inc};
  assign idx_ext     = {4'b0, chk_pos_r};
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_index = out_idx_r;
  assign out_ch.occupied   = out_occ_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      iss_r       <= 1'b0;
      chk_v_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      chk_v_r     <= chk_v_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    chk_pos_r    <= chk_pos_nxt;
    chk_last_r   <= chk_last_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Next state: clear pass, dispatch, pipelined probe and check
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    chk_v_nxt      = 1'b0;
    chk_pos_nxt    = chk_pos_r;
    chk_last_nxt   = chk_last_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_occ_nxt    = out_occ_r;
    q_ready        = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = clr_r;
    mem_wd         = EMPTY_KEY;
    mem_re         = 1'b0;
    mem_ra         = pos_r;

    case (state_r)
      BK_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = BK_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end

      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          if (q_res) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_RESERVED;
            out_idx_nxt    = 4'd0;
            out_occ_nxt    = occ_now_ext[3:0];
          end else begin
            op_nxt    = q_op;
            key_nxt   = q_key;
            pos_nxt   = q_home;
            cnt_nxt   = '0;
            iss_nxt   = 1'b1;
            state_nxt = BK_PROBE;
          end
        end
      end

      BK_PROBE: begin
        // Issue one slot read a cycle until every slot has been read
        if (iss_r) begin
          mem_re       = 1'b1;
          chk_v_nxt    = 1'b1;
          chk_pos_nxt  = pos_r;
          chk_last_nxt = (cnt_r == LAST_IDX);
          pos_nxt      = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
          cnt_nxt      = cnt_r + IDX_W'(1);
          iss_nxt      = (cnt_r != LAST_IDX);
        end
        // Check the slot read last cycle; drop reads in flight on finish
        if (chk_v_r) begin
          if (op_r == REQ_INSERT) begin
            if (rd_data_r == EMPTY_KEY) begin
              mem_we         = 1'b1;
              mem_wa         = chk_pos_r;
              mem_wd         = key_r;
              fill_nxt       = fill_inc;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INSERTED;
              out_idx_nxt    = idx_ext[3:0];
              out_occ_nxt    = occ_inc_ext[3:0];
              state_nxt      = BK_IDLE;
              iss_nxt        = 1'b0;
              chk_v_nxt      = 1'b0;
            end else if (chk_last_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              out_idx_nxt    = 4'd0;
              out_occ_nxt    = occ_now_ext[3:0];
              state_nxt      = BK_IDLE;
              iss_nxt        = 1'b0;
              chk_v_nxt      = 1'b0;
            end
          end else begin
            if (rd_data_r == key_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FOUND;
              out_idx_nxt    = idx_ext[3:0];
              out_occ_nxt    = occ_now_ext[3:0];
              state_nxt      = BK_IDLE;
              iss_nxt        = 1'b0;
              chk_v_nxt      = 1'b0;
            end else if ((rd_data_r == EMPTY_KEY) || chk_last_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_FOUND;
              out_idx_nxt    = 4'd0;
              out_occ_nxt    = occ_now_ext[3:0];
              state_nxt      = BK_IDLE;
              iss_nxt        = 1'b0;
              chk_v_nxt      = 1'b0;
            end
          end
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

endmodule
